// ===== src/frce_pkg.sv =====
// ----------------------------------------------------------------------------
// frce_pkg: shared types and constants of the range count engine
// Field widths of the request and response channels, operation codes,
// the largest response count and the controller state type.
// ----------------------------------------------------------------------------
package frce_pkg;

   // Request and response field widths.
   localparam int OPERATION_W = 1;
   localparam int EMPLOYEE_W  = 8;
   localparam int VALUE_W     = 10;
   localparam int MATCH_W     = 9;

   // Operation codes.
   localparam logic [OPERATION_W-1:0] OP_SET   = 1'b0;
   localparam logic [OPERATION_W-1:0] OP_COUNT = 1'b1;

   // Largest count the response field can carry.
   localparam logic [MATCH_W-1:0] COUNT_MAX = 9'd511;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EMP_WAIT,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SUM,
      ST_FINISH
   } state_type;

endpackage

// ===== src/frce_if.sv =====
// ----------------------------------------------------------------------------
// frce_if: request and response channels of the range count engine
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface frce_req_if;
   import frce_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OPERATION_W-1:0] operation;
   logic [EMPLOYEE_W-1:0]  employee;
   logic [VALUE_W-1:0]     new_value;
   logic [VALUE_W-1:0]     range_low;
   logic [VALUE_W-1:0]     range_high;

   modport source (output valid, operation, employee, new_value, range_low, range_high,
                   input ready);
   modport sink   (input valid, operation, employee, new_value, range_low, range_high,
                   output ready);
endinterface

interface frce_rsp_if;
   import frce_pkg::*;

   logic               valid;
   logic               ready;
   logic [MATCH_W-1:0] match_count;

   modport source (output valid, match_count, input ready);
   modport sink   (input valid, match_count, output ready);
endinterface

// ===== src/frce_ram.sv =====
// ----------------------------------------------------------------------------
// frce_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module frce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== src/fenwick_range_count_engine.sv =====
// ----------------------------------------------------------------------------
// fenwick_range_count_engine: employee value store with range counting
// Keeps one value per employee and a Fenwick tree of value counts in RAM.
// ----------------------------------------------------------------------------
// After reset the block clears both RAMs in a pass over addresses 0 to
// max(EMPLOYEES, VALUE_RANGE)-1, during which it takes no request. Requests
// are then handled one at a time. A set request reads the employee entry,
// then walks the tree once or twice with one read-modify-write per node,
// pipelined through the tree RAM; one with an out-of-range employee or value
// is dropped. A count request walks two prefix sums, one tree read per node;
// an empty range skips the walk. A set request gives no response; the
// response register lets the next request in while a count waits to be taken.
module fenwick_range_count_engine #(
   parameter int EMPLOYEES   = 256,
   parameter int VALUE_RANGE = 1024
) (
   input  logic       clock,
   input  logic       reset,
   frce_req_if.sink   req,
   frce_rsp_if.source rsp
);
   import frce_pkg::*;

   // Derived widths.
   localparam int EA_W      = (EMPLOYEES > 1) ? $clog2(EMPLOYEES) : 1;
   localparam int VA_W      = $clog2(VALUE_RANGE);
   localparam int K_W       = $clog2(VALUE_RANGE + 1);
   localparam int CNT_W     = $clog2(EMPLOYEES + 1);
   localparam int CLR_DEPTH = (EMPLOYEES > VALUE_RANGE) ? EMPLOYEES : VALUE_RANGE;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int CMP_W     = (CNT_W > MATCH_W) ? CNT_W : MATCH_W;
   localparam int EW_W      = VALUE_W + 1;

   localparam logic [15:0]    VAL_LAST  = 16'(VALUE_RANGE - 1);
   localparam logic [K_W:0]   K_LIMIT   = (K_W + 1)'(VALUE_RANGE);
   localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

   // Controller and datapath registers.
   state_type         state_ff, state_in;
   logic [CLR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [K_W-1:0]    lo_k_ff, lo_k_in;
   logic [VALUE_W-1:0] set_val_ff, set_val_in;
   logic [EA_W-1:0]   emp_ff, emp_in;
   logic              dec_ff, dec_in;
   logic              phase_ff, phase_in;
   logic              pending_ff, pending_in;
   logic              sub_tag_ff, sub_tag_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MATCH_W-1:0] rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic              tree_we;
   logic [VA_W-1:0]   tree_waddr, tree_raddr;
   logic [CNT_W-1:0]  tree_wdata, tree_rdata;
   logic              emp_we;
   logic [EA_W-1:0]   emp_waddr, emp_raddr;
   logic [EW_W-1:0]   emp_wdata, emp_rdata;

   // Request decode.
   logic              accept;
   logic [15:0]       emp_ext, val_ext, lo_ext, hi_raw, hi_ext;
   logic              set_ok, range_empty;
   logic [K_W:0]      k_wide, k_up;
   logic [K_W-1:0]    k_low, k_down, k_minus1, old_k;
   logic              done_walk;
   logic              load_rsp;
   logic [CMP_W-1:0]  acc_ext;

   assign accept  = req.valid && req.ready;
   assign emp_ext = 16'(req.employee);
   assign val_ext = 16'(req.new_value);
   assign lo_ext  = 16'(req.range_low);
   assign hi_raw  = 16'(req.range_high);
   assign hi_ext  = (hi_raw > VAL_LAST) ? VAL_LAST : hi_raw;
   assign set_ok  = ({1'b0, emp_ext} < 17'(EMPLOYEES)) &&
                    ({1'b0, val_ext} < 17'(VALUE_RANGE));
   assign range_empty = lo_ext > hi_ext;

   // Tree index arithmetic: lowest set bit, the step up and the step down.
   assign k_low     = k_ff & (~k_ff + K_W'(1));
   assign k_wide    = {1'b0, k_ff};
   assign k_up      = k_wide + {1'b0, k_low};
   assign k_down    = k_ff - k_low;
   assign k_minus1  = k_ff - K_W'(1);
   assign done_walk = k_up > K_LIMIT;
   assign old_k     = K_W'(emp_rdata[VALUE_W-1:0]) + K_W'(1);

   // The response waits in its register until the sink takes it.
   assign load_rsp = (state_ff == ST_FINISH) && !rsp_valid_ff;
   assign acc_ext  = CMP_W'(acc_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.operation == OP_SET) begin
                  if (set_ok) state_in = ST_EMP_WAIT;
               end else if (range_empty) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_EMP_WAIT: state_in = ST_ADD_RD;
         ST_ADD_RD:   state_in = ST_ADD_WR;
         ST_ADD_WR: begin
            if (done_walk) state_in = dec_ff ? ST_ADD_RD : ST_IDLE;
         end
         ST_SUM: begin
            if (k_ff == '0 && phase_ff && !pending_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory controls and request ready.
   always_comb begin
      req.ready  = 1'b0;
      tree_we    = 1'b0;
      tree_waddr = k_minus1[VA_W-1:0];
      tree_wdata = dec_ff ? (tree_rdata - CNT_W'(1)) : (tree_rdata + CNT_W'(1));
      tree_raddr = k_minus1[VA_W-1:0];
      emp_we     = 1'b0;
      emp_waddr  = emp_ff;
      emp_wdata  = {1'b1, set_val_ff};
      emp_raddr  = emp_ext[EA_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            tree_we    = 17'(clr_cnt_ff) < 17'(VALUE_RANGE);
            tree_waddr = clr_cnt_ff[VA_W-1:0];
            tree_wdata = '0;
            emp_we     = 17'(clr_cnt_ff) < 17'(EMPLOYEES);
            emp_waddr  = clr_cnt_ff[EA_W-1:0];
            emp_wdata  = '0;
         end
         ST_IDLE: req.ready = 1'b1;
         ST_EMP_WAIT: emp_we = 1'b1;
         ST_ADD_WR: begin
            // Write this node and read the next one, a different entry.
            tree_we    = 1'b1;
            tree_raddr = VA_W'(k_up - (K_W + 1)'(1));
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      k_in         = k_ff;
      lo_k_in      = lo_k_ff;
      set_val_in   = set_val_ff;
      emp_in       = emp_ff;
      dec_in       = dec_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      sub_tag_in   = sub_tag_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_CLEAR: clr_cnt_in = clr_cnt_ff + CLR_W'(1);
         ST_IDLE: begin
            if (accept) begin
               set_val_in = req.new_value;
               emp_in     = emp_ext[EA_W-1:0];
               lo_k_in    = K_W'(lo_ext);
               k_in       = K_W'(hi_ext) + K_W'(1);
               phase_in   = 1'b0;
               pending_in = 1'b0;
               acc_in     = '0;
            end
         end
         ST_EMP_WAIT: begin
            // A held value is taken out of the tree before the new one goes in.
            dec_in = emp_rdata[VALUE_W];
            k_in   = emp_rdata[VALUE_W] ? old_k : (K_W'(set_val_ff) + K_W'(1));
         end
         ST_ADD_WR: begin
            if (!done_walk) begin
               k_in = k_up[K_W-1:0];
            end else if (dec_ff) begin
               dec_in = 1'b0;
               k_in   = K_W'(set_val_ff) + K_W'(1);
            end
         end
         ST_SUM: begin
            // Add the upper prefix, then subtract the lower one.
            if (pending_ff) begin
               acc_in = sub_tag_ff ? (acc_ff - tree_rdata) : (acc_ff + tree_rdata);
            end
            if (k_ff != '0) begin
               k_in       = k_down;
               pending_in = 1'b1;
               sub_tag_in = phase_ff;
            end else begin
               pending_in = 1'b0;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  k_in     = lo_k_ff;
               end
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = (acc_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                            : acc_ext[MATCH_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      lo_k_ff      <= lo_k_in;
      set_val_ff   <= set_val_in;
      emp_ff       <= emp_in;
      dec_ff       <= dec_in;
      phase_ff     <= phase_in;
      sub_tag_ff   <= sub_tag_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.match_count = rsp_count_ff;

   // Employee store: valid mark and value in one word.
   frce_ram #(
      .WIDTH (EW_W),
      .DEPTH (EMPLOYEES),
      .AW    (EA_W)
   ) u_emp_ram (
      .clock (clock),
      .we    (emp_we),
      .waddr (emp_waddr),
      .wdata (emp_wdata),
      .raddr (emp_raddr),
      .rdata (emp_rdata)
   );

   // Fenwick tree: node k lives at address k-1.
   frce_ram #(
      .WIDTH (CNT_W),
      .DEPTH (VALUE_RANGE),
      .AW    (VA_W)
   ) u_tree_ram (
      .clock (clock),
      .we    (tree_we),
      .waddr (tree_waddr),
      .wdata (tree_wdata),
      .raddr (tree_raddr),
      .rdata (tree_rdata)
   );

   // A response is only loaded from the finishing state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finishing state");

   // A tree update never reads the entry it writes in the same cycle, the last node of a walk apart.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_WR) |-> (tree_raddr != tree_waddr || done_walk))
      else $error("tree read collides with tree write");

   // The update walk stays on tree nodes 1 to VALUE_RANGE.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD_RD || state_ff == ST_ADD_WR) |->
         (k_ff != '0 && {1'b0, k_ff} <= K_LIMIT))
      else $error("tree index out of range during update");

   // No request is taken while the clearing pass runs.
   a_no_accept_clear: assert property (@(posedge clock)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request ready during clearing pass");

   // A pending sum read only ever follows a sum cycle.
   a_pending_in_sum: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> $past(state_ff == ST_SUM))
      else $error("tree sum read pending outside the sum walk");

endmodule
